// File: rtl/pmq_pkg.sv
package pmq_pkg;

  typedef logic [1:0]  qid_t;
  typedef logic [7:0]  tid_t;
  typedef logic [15:0] handle_t;
  typedef logic [11:0] length_t;
  typedef logic [4:0]  prio_t;

  localparam int QID_W = $bits(qid_t);

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_SENT     = 3'd0,
    ST_RECEIVED = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_QFULL    = 3'd3,
    ST_WFULL    = 3'd4
  } status_t;

  typedef struct packed {
    handle_t handle;
    length_t length;
    prio_t   prio;
  } msg_entry_t;

  typedef struct packed {
    logic       ins;
    logic       pop;
    msg_entry_t entry;
  } msg_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    msg_entry_t head;
  } msg_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
    tid_t tid;
  } wait_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    tid_t head;
  } wait_stat_t;

  typedef struct packed {
    status_t status;
    handle_t handle;
    length_t length;
    prio_t   prio;
    logic    wake_valid;
    tid_t    wake_thread;
  } result_t;

endpackage

// File: rtl/pmq_if.sv
interface pmq_in_if
  import pmq_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    operation;
  qid_t    queue_id;
  tid_t    thread_id;
  handle_t msg_handle;
  length_t msg_length;
  prio_t   msg_priority;

  modport source (
    output valid, operation, queue_id, thread_id, msg_handle, msg_length, msg_priority,
    input  ready
  );
  modport sink (
    input  valid, operation, queue_id, thread_id, msg_handle, msg_length, msg_priority,
    output ready
  );
endinterface

interface pmq_out_if
  import pmq_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t status;
  handle_t out_handle;
  length_t out_length;
  prio_t   out_priority;
  logic    wake_valid;
  tid_t    wake_thread;

  modport source (
    output valid, status, out_handle, out_length, out_priority, wake_valid, wake_thread,
    input  ready
  );
  modport sink (
    input  valid, status, out_handle, out_length, out_priority, wake_valid, wake_thread,
    output ready
  );
endinterface

// File: rtl/priority_message_queue_unit.sv
// channel    port      dir  beat
// request    in_chan   in   operation, queue_id, thread_id, msg_handle, msg_length, msg_priority
// response   out_chan  out  status, out_handle, out_length, out_priority, wake_valid, wake_thread
//
// one request per cycle; its response is registered and shows in the cycle after acceptance
// the request and the queue state are settled in the accepting cycle by the selected queue's cell row
// reset clears the message and waiter counts of every queue; cell contents are left as they are
// a stalled response holds its register; a new request is taken when that register is free or
// is being drained in the same cycle
module priority_message_queue_unit
  import pmq_pkg::*;
#(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int WAIT_DEPTH  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pmq_in_if.sink     in_chan,
  pmq_out_if.source  out_chan
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  logic    acc;
  qid_t    q_red;
  logic [QW-1:0] q_idx;
  msg_cmd_t   [NUM_QUEUES-1:0] mcmd;
  msg_stat_t  [NUM_QUEUES-1:0] mstat;
  wait_cmd_t  [NUM_QUEUES-1:0] wcmd;
  wait_stat_t [NUM_QUEUES-1:0] wstat;
  msg_stat_t  ms;
  wait_stat_t ws;
  logic    m_ins;
  logic    m_pop;
  logic    w_push;
  logic    w_pop;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    out_valid_nxt;

  assign acc           = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !out_valid_r || out_chan.ready;

  // queue id reduced modulo the queue count
  always_comb begin
    q_red = in_chan.queue_id;
    for (int k = 0; k < 3; k++) begin
      if (int'(q_red) >= NUM_QUEUES) begin
        q_red = q_red - QID_W'(NUM_QUEUES);
      end
    end
  end

  assign q_idx = QW'(q_red);
  assign ms    = mstat[q_idx];
  assign ws    = wstat[q_idx];

  always_comb begin
    m_ins  = 1'b0;
    m_pop  = 1'b0;
    w_push = 1'b0;
    w_pop  = 1'b0;
    res    = '0;
    if (op_t'(in_chan.operation) == OP_SEND) begin
      if (ms.full) begin
        res.status = ST_QFULL;
      end else begin
        m_ins      = 1'b1;
        res.status = ST_SENT;
        if (ms.empty && !ws.empty) begin
          w_pop           = 1'b1;
          res.wake_valid  = 1'b1;
          res.wake_thread = ws.head;
        end
      end
    end else begin
      if (!ms.empty) begin
        m_pop      = 1'b1;
        res.status = ST_RECEIVED;
        res.handle = ms.head.handle;
        res.length = ms.head.length;
        res.prio   = ms.head.prio;
      end else if (ws.full) begin
        res.status = ST_WFULL;
      end else begin
        w_push     = 1'b1;
        res.status = ST_BLOCKED;
      end
    end
  end

  for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
    logic sel;

    assign sel = acc && (q_idx == QW'(q));

    assign mcmd[q].ins          = sel && m_ins;
    assign mcmd[q].pop          = sel && m_pop;
    assign mcmd[q].entry.handle = in_chan.msg_handle;
    assign mcmd[q].entry.length = in_chan.msg_length;
    assign mcmd[q].entry.prio   = in_chan.msg_priority;

    assign wcmd[q].push = sel && w_push;
    assign wcmd[q].pop  = sel && w_pop;
    assign wcmd[q].tid  = in_chan.thread_id;

    pmq_msg_row #(
      .DEPTH (QUEUE_DEPTH)
    ) u_msg_row (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (mcmd[q]),
      .stat  (mstat[q])
    );

    pmq_wait_row #(
      .DEPTH (WAIT_DEPTH)
    ) u_wait_row (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (wcmd[q]),
      .stat  (wstat[q])
    );
  end

  assign out_valid_nxt = acc || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = res_r.status;
  assign out_chan.out_handle   = res_r.handle;
  assign out_chan.out_length   = res_r.length;
  assign out_chan.out_priority = res_r.prio;
  assign out_chan.wake_valid   = res_r.wake_valid;
  assign out_chan.wake_thread  = res_r.wake_thread;

endmodule

// File: rtl/pmq_msg_cell.sv
module pmq_msg_cell
  import pmq_pkg::*;
(
  input  logic       clk,
  input  msg_cmd_t   cmd,
  input  logic       occupied,
  input  logic       left_ge,
  input  msg_entry_t left_entry,
  input  msg_entry_t right_entry,
  output logic       ge,
  output msg_entry_t entry
);

  msg_entry_t entry_r;
  msg_entry_t entry_nxt;

  assign ge    = occupied && (entry_r.prio >= cmd.entry.prio);
  assign entry = entry_r;

  // insert: cells past the slot take their left neighbour, the slot takes the new entry
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.pop) begin
      entry_nxt = right_entry;
    end else if (cmd.ins) begin
      if (!left_ge) begin
        entry_nxt = left_entry;
      end else if (!ge) begin
        entry_nxt = cmd.entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: rtl/pmq_msg_row.sv
module pmq_msg_row
  import pmq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  msg_cmd_t  cmd,
  output msg_stat_t stat
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic       [DEPTH-1:0] ge;
  msg_entry_t [DEPTH-1:0] ents;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       left_ge;
    msg_entry_t left_entry;
    msg_entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = cmd.entry;
    end else begin : g_inner
      assign left_ge    = ge[i-1];
      assign left_entry = ents[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = ents[i];
    end else begin : g_body
      assign right_entry = ents[i+1];
    end

    pmq_msg_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CW'(i) < cnt_r),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (ge[i]),
      .entry       (ents[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.head  = ents[0];

endmodule

// File: rtl/pmq_wait_row.sv
module pmq_wait_row
  import pmq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  wait_cmd_t  cmd,
  output wait_stat_t stat
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  tid_t [DEPTH-1:0] tid_r;

  // oldest waiter sits in the first cell; a pop shifts the row one place
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tid_t right_tid;
    tid_t tid_nxt;

    if (i == DEPTH - 1) begin : g_last
      assign right_tid = tid_r[i];
    end else begin : g_body
      assign right_tid = tid_r[i+1];
    end

    always_comb begin
      tid_nxt = tid_r[i];
      if (cmd.pop) begin
        tid_nxt = right_tid;
      end else if (cmd.push && (cnt_r == CW'(i))) begin
        tid_nxt = cmd.tid;
      end
    end

    always_ff @(posedge clk) begin
      tid_r[i] <= tid_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.head  = tid_r[0];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pmq_pkg::*;

  localparam int NQ          = 4;
  localparam int QDEPTH      = 16;
  localparam int WDEPTH      = 8;
  localparam int N_OPEN      = 25;
  localparam int RAND_BEATS  = 1700;
  localparam int HOLD_AFTER  = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    op_t     op;
    qid_t    qid;
    tid_t    tid;
    handle_t handle;
    length_t length;
    prio_t   prio;
    logic    typed;
    result_t want;
  } req_beat_t;

  logic clk;
  logic rst_n;

  pmq_in_if  in_chan ();
  pmq_out_if out_chan ();

  priority_message_queue_unit #(
    .NUM_QUEUES  (NQ),
    .QUEUE_DEPTH (QDEPTH),
    .WAIT_DEPTH  (WDEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // opening beats: op, queue, thread, handle, length, prio, typed, expected result
  req_beat_t opening_rows [N_OPEN] = '{
    '{OP_RECV, 2'd0, 8'hff, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_SEND, 2'd0, 8'h00, 16'hffff, 12'hfff, 5'd31, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b1, 8'hff}},
    '{OP_SEND, 2'd0, 8'h00, 16'h0000, 12'h000, 5'd0, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_SEND, 2'd0, 8'h00, 16'h1234, 12'h0ab, 5'd31, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_SEND, 2'd0, 8'h00, 16'h5555, 12'h555, 5'd16, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd0, 8'h00, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_RECEIVED, 16'hffff, 12'hfff, 5'd31, 1'b0, 8'h00}},
    '{OP_RECV, 2'd0, 8'h00, 16'h0, 12'h0, 5'd0, 1'b0, '0},
    '{OP_RECV, 2'd0, 8'h00, 16'h0, 12'h0, 5'd0, 1'b0, '0},
    '{OP_RECV, 2'd0, 8'h00, 16'h0, 12'h0, 5'd0, 1'b0, '0},
    '{OP_RECV, 2'd0, 8'h00, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_SEND, 2'd0, 8'h00, 16'haaaa, 12'haaa, 5'd10, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b1, 8'h00}},
    '{OP_RECV, 2'd3, 8'h01, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h02, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h04, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h08, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h10, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h20, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h40, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h80, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_BLOCKED, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h7f, 16'h0, 12'h0, 5'd0, 1'b1,
      '{ST_WFULL, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_SEND, 2'd3, 8'h00, 16'h00ff, 12'h800, 5'd1, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b1, 8'h01}},
    '{OP_SEND, 2'd3, 8'h00, 16'hff00, 12'h7ff, 5'd2, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b0, 8'h00}},
    '{OP_RECV, 2'd3, 8'h33, 16'h0, 12'h0, 5'd0, 1'b0, '0},
    '{OP_RECV, 2'd3, 8'h44, 16'h0, 12'h0, 5'd0, 1'b0, '0},
    '{OP_SEND, 2'd3, 8'h00, 16'h0001, 12'h001, 5'd30, 1'b1,
      '{ST_SENT, 16'h0, 12'h0, 5'd0, 1'b1, 8'h02}}
  };

  msg_entry_t  stored_msgs [NQ][$];
  tid_t        waiting_tids [NQ][$];
  result_t     due_results [$];
  req_beat_t   beat_stim [$];
  req_beat_t   on_wire = '0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  function automatic result_t predict_delivery(req_beat_t b);
    result_t    r;
    msg_entry_t e;
    int         q;
    int         pos;
    r = '0;
    q = int'(b.qid) % NQ;
    if (b.op == OP_SEND) begin
      if (stored_msgs[q].size() >= QDEPTH) begin
        r.status = ST_QFULL;
      end else begin
        e = '{b.handle, b.length, b.prio};
        pos = 0;
        // behind every entry of equal or higher priority
        while (pos < stored_msgs[q].size() && stored_msgs[q][pos].prio >= b.prio) pos++;
        r.status = ST_SENT;
        if (stored_msgs[q].size() == 0 && waiting_tids[q].size() > 0) begin
          r.wake_valid  = 1'b1;
          r.wake_thread = waiting_tids[q].pop_front();
        end
        stored_msgs[q].insert(pos, e);
      end
    end else if (stored_msgs[q].size() > 0) begin
      e = stored_msgs[q].pop_front();
      r.status = ST_RECEIVED;
      r.handle = e.handle;
      r.length = e.length;
      r.prio   = e.prio;
    end else if (waiting_tids[q].size() >= WDEPTH) begin
      r.status = ST_WFULL;
    end else begin
      waiting_tids[q].push_back(b.tid);
      r.status = ST_BLOCKED;
    end
    return r;
  endfunction

  function automatic req_beat_t rand_beat(op_t op, int q);
    req_beat_t b;
    b = '0;
    b.op     = op;
    b.qid    = qid_t'(q);
    b.tid    = tid_t'($urandom);
    b.handle = handle_t'($urandom);
    b.length = length_t'($urandom);
    // narrow priorities often, so that equal priorities meet
    b.prio   = ($urandom_range(0, 1) == 1) ? prio_t'($urandom_range(0, 31))
                                           : prio_t'($urandom_range(0, 3));
    return b;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got 0x%0h expected 0x%0h at out beat %0d",
             what, got, want, beats_out);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    result_t seen;
    if (rst_n) begin
      idle_cycles++;
      if (out_chan.valid && out_chan.ready) begin
        idle_cycles = 0;
        seen = '{out_chan.status, out_chan.out_handle, out_chan.out_length,
                 out_chan.out_priority, out_chan.wake_valid, out_chan.wake_thread};
        if (due_results.size() == 0) begin
          report_mismatch("beat with nothing due", seen, 0);
        end else begin
          want = due_results.pop_front();
          if (seen.status != want.status) report_mismatch("status", seen.status, want.status);
          if (seen.handle != want.handle) report_mismatch("handle", seen.handle, want.handle);
          if (seen.length != want.length) report_mismatch("length", seen.length, want.length);
          if (seen.prio != want.prio) report_mismatch("priority", seen.prio, want.prio);
          if (seen.wake_valid != want.wake_valid) begin
            report_mismatch("wake_valid", seen.wake_valid, want.wake_valid);
          end
          if (seen.wake_thread != want.wake_thread) begin
            report_mismatch("wake_thread", seen.wake_thread, want.wake_thread);
          end
        end
        beats_out++;
      end
      if (in_chan.valid && in_chan.ready) begin
        idle_cycles = 0;
        want = predict_delivery(on_wire);
        if (on_wire.typed) want = on_wire.want;
        due_results.push_back(want);
        beats_in++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : receiver
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    forever begin
      // one long hold so the result register and then the input back up
      if (!held && beats_in >= HOLD_AFTER) begin
        held = 1'b1;
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 40);
      repeat (span) begin
        case (mode)
          0: out_chan.ready = 1'b1;
          1: out_chan.ready = ($urandom_range(0, 1) == 1);
          2: out_chan.ready = ($urandom_range(0, 3) == 0);
          default: out_chan.ready = ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : sender
    int kind;
    int q;
    int n;
    int idx;
    int burst;
    int gap;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.operation    = OP_SEND;
    in_chan.queue_id     = '0;
    in_chan.thread_id    = '0;
    in_chan.msg_handle   = '0;
    in_chan.msg_length   = '0;
    in_chan.msg_priority = '0;

    for (idx = 0; idx < N_OPEN; idx++) beat_stim.push_back(opening_rows[idx]);
    while (beat_stim.size() < N_OPEN + RAND_BEATS) begin
      kind = $urandom_range(0, 9);
      q    = $urandom_range(0, NQ - 1);
      if (kind < 4) begin
        // fill a queue, sometimes past full, then drain it and often block
        n = $urandom_range(1, QDEPTH + 2);
        repeat (n) beat_stim.push_back(rand_beat(OP_SEND, q));
        repeat ($urandom_range(n, n + 3)) beat_stim.push_back(rand_beat(OP_RECV, q));
      end else if (kind < 7) begin
        // park waiters, then wake them one send at a time
        n = $urandom_range(1, WDEPTH + 2);
        repeat (n) beat_stim.push_back(rand_beat(OP_RECV, q));
        repeat ($urandom_range(1, n)) begin
          beat_stim.push_back(rand_beat(OP_SEND, q));
          beat_stim.push_back(rand_beat(OP_RECV, q));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          beat_stim.push_back(rand_beat(op_t'($urandom_range(0, 1)),
                                        $urandom_range(0, NQ - 1)));
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idx = 0;
    while (idx < beat_stim.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && idx < beat_stim.size()) begin
        on_wire              = beat_stim[idx];
        in_chan.operation    = on_wire.op;
        in_chan.queue_id     = on_wire.qid;
        in_chan.thread_id    = on_wire.tid;
        in_chan.msg_handle   = on_wire.handle;
        in_chan.msg_length   = on_wire.length;
        in_chan.msg_priority = on_wire.prio;
        in_chan.valid        = 1'b1;
        @(posedge clk);
        while (!in_chan.ready) @(posedge clk);
        @(negedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_chan.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_chan.valid = 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
